// ----- sv/binary_trie_longest_prefix_match_unit_defines.svh -----
// Assertion macros shared by the trie block.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH

// Implication checked at every edge outside reset.
`define BTL_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BTL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- sv/btlpm_pkg.sv -----
`default_nettype none
package btlpm_pkg;
    localparam int NodePool = 4096;
    localparam int AddrBits = 32;
    localparam int PortBits = 8;
    localparam int LenBits  = 6;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_STEP,
        ST_ALLOC,
        ST_MARK,
        ST_FETCH,
        ST_DONE
    } walk_state_t;
endpackage
`default_nettype wire

// ----- sv/btlpm_front.sv -----
`default_nettype none
// Accept items, saturate the length and hold them in a two-entry queue.
module btlpm_front #(
    parameter int ADDR_BITS = 32,
    parameter int PORT_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [ADDR_BITS-1:0] s_addr,
    input  wire logic [5:0]           s_len,
    input  wire logic [PORT_BITS-1:0] s_port,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output logic                      q_mode,
    output logic [ADDR_BITS-1:0]      q_addr,
    output logic [5:0]                q_len,
    output logic [PORT_BITS-1:0]      q_port
);
    import btlpm_pkg::*;
    `include "binary_trie_longest_prefix_match_unit_defines.svh"

    localparam int W = 1 + ADDR_BITS + 6 + PORT_BITS;
    localparam logic [5:0] MaxLen = 6'(ADDR_BITS > 63 ? 63 : ADDR_BITS);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [5:0]   len_sat;
    logic         push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    // clamp lengths beyond the address width
    assign len_sat = (s_len > MaxLen) ? MaxLen : s_len;
    assign {q_mode, q_addr, q_len, q_port} = slot_reg[rd_ptr_reg];

    // store incoming items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {s_mode, s_addr, len_sat, s_port};
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    `BTL_ASSERT_IMP(a_q_len_ok, clk, rst_n, q_valid, q_len <= MaxLen, "queued length too long")
    `BTL_ASSERT_IMP(a_cnt_ok, clk, rst_n, 1'b1, count_reg != 2'd3, "queue count overflow")
    `BTL_ASSERT_NEXT(a_full_hold, clk, rst_n, count_reg == 2'd2 && !pop, count_reg == 2'd2,
        "full queue lost an item")
endmodule
`default_nettype wire

// ----- sv/btlpm_walk.sv -----
`default_nettype none
// Walk the trie level by level through read, wait and step states; insert or look up.
module btlpm_walk #(
    parameter int NODE_POOL = 4096,
    parameter int ADDR_BITS = 32,
    parameter int PORT_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire logic                 q_mode,
    input  wire logic [ADDR_BITS-1:0] q_addr,
    input  wire logic [5:0]           q_len,
    input  wire logic [PORT_BITS-1:0] q_port,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    output logic [PORT_BITS-1:0]      m_port,
    output logic [5:0]                m_len,
    output logic [ADDR_BITS-1:0]      m_prefix,
    output logic                      m_full,
    output logic [12:0]               m_nodes
);
    import btlpm_pkg::*;
    `include "binary_trie_longest_prefix_match_unit_defines.svh"

    localparam int NB = $clog2(NODE_POOL);
    localparam int CB = NB + 1;
    localparam int RW = PORT_BITS + 6 + ADDR_BITS;
    localparam int AB = $clog2(ADDR_BITS);

    // node memories: child pair and route record
    logic [2*NB-1:0] link_mem  [NODE_POOL];
    logic [RW-1:0]   route_mem [NODE_POOL];
    logic            mark_mem  [NODE_POOL];

    walk_state_t state_reg, state_next;
    logic                 mode_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [5:0]           len_reg;
    logic [PORT_BITS-1:0] port_reg;
    logic [5:0]           depth_reg, depth_next;
    logic [NB-1:0]        node_reg, node_next;
    logic [NB-1:0]        found_reg, found_next;
    logic                 hit_reg, hit_next;
    logic [CB-1:0]        alloc_reg, alloc_next;
    logic                 root_mark_reg;
    logic [2*NB-1:0]      root_link_reg;
    logic                 full_reg;
    logic                 fresh_cur_reg;
    logic [2*NB-1:0]      link_rd;
    logic [2*NB-1:0]      link_cur;
    logic                 mark_rd;
    logic [RW-1:0]        route_rd;
    logic                 out_full_next;
    logic                 load, take_out;
    logic                 bit_cur;
    logic [NB-1:0]        child;
    logic                 link_we, route_we, fresh_we;
    logic [NB-1:0]        fresh;
    logic [2*NB-1:0]      link_wd;
    logic [CB:0]          need;
    logic                 mark_eff;
    logic [NB-1:0]        rd_idx;

    assign q_ready  = (state_reg == ST_IDLE);
    assign load     = q_valid && q_ready;
    assign take_out = m_valid && m_ready;
    assign bit_cur  = addr_reg[AB'(ADDR_BITS - 1) - depth_reg[AB-1:0]];
    // root links live in flops; a node allocated last cycle has no children yet
    assign link_cur = (node_reg == '0) ? root_link_reg : (fresh_cur_reg ? '0 : link_rd);
    assign child    = bit_cur ? link_cur[2*NB-1:NB] : link_cur[NB-1:0];
    assign fresh    = alloc_reg[NB-1:0];
    // root fields held in flops so the root needs no clearing pass
    assign mark_eff = (node_reg == '0) ? root_mark_reg : mark_rd;
    assign need     = (CB+1)'(alloc_reg) + (CB+1)'(len_reg - depth_reg);

    // read ports with registered data
    always_ff @(posedge clk)
    begin
        link_rd  <= link_mem[rd_idx];
        mark_rd  <= mark_mem[rd_idx];
        route_rd <= route_mem[rd_idx];
        if (link_we)  link_mem[node_reg] <= link_wd;
        if (fresh_we)
        begin
            link_mem[fresh] <= '0;
            mark_mem[fresh] <= 1'b0;
        end
        if (route_we)
        begin
            mark_mem[node_reg]  <= 1'b1;
            route_mem[node_reg] <= {port_reg, len_reg, addr_reg};
        end
    end

    // next state and memory controls
    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        node_next     = node_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        alloc_next    = alloc_reg;
        out_full_next = full_reg;
        link_we       = 1'b0;
        fresh_we      = 1'b0;
        route_we      = 1'b0;
        link_wd       = link_cur;
        rd_idx        = node_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_RD;
                    depth_next = '0;
                    node_next  = '0;
                    found_next = '0;
                    hit_next   = 1'b0;
                end
            end
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                // check mark of the current node on a lookup
                if (mode_reg == MODE_LOOKUP && mark_eff && (node_reg != '0 || root_mark_reg))
                begin
                    hit_next   = 1'b1;
                    found_next = node_reg;
                end
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (depth_reg < len_reg && child != '0)
                begin
                    node_next  = child;
                    depth_next = depth_reg + 6'd1;
                    state_next = ST_RD;
                end
                else if (mode_reg == MODE_LOOKUP)
                begin
                    state_next = ST_FETCH;
                    rd_idx     = found_reg;
                end
                else if (need > (CB+1)'(NODE_POOL))
                begin
                    out_full_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (depth_reg < len_reg)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    state_next = ST_MARK;
                end
            end
            ST_ALLOC:
            begin
                // link a fresh node and descend; fresh node has no children
                link_we  = 1'b1;
                link_wd  = bit_cur ? {fresh, link_cur[NB-1:0]} : {link_cur[2*NB-1:NB], fresh};
                fresh_we = 1'b1;
                node_next  = fresh;
                depth_next = depth_reg + 6'd1;
                alloc_next = alloc_reg + CB'(1);
                if (depth_reg + 6'd1 < len_reg)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                route_we   = 1'b1;
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                // keep the route record of the match on the read port
                rd_idx     = found_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rd_idx = found_reg;
                if (!m_valid || take_out) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_reg     <= CB'(1);
            root_mark_reg <= 1'b0;
            root_link_reg <= '0;
            m_valid       <= 1'b0;
            fresh_cur_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alloc_reg <= alloc_next;
            fresh_cur_reg <= (state_reg == ST_ALLOC);
            if (route_we && node_reg == '0) root_mark_reg <= 1'b1;
            if (link_we && node_reg == '0) root_link_reg <= link_wd;
            if (state_reg == ST_DONE && (!m_valid || take_out)) m_valid <= 1'b1;
            else if (take_out) m_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        depth_reg <= depth_next;
        node_reg  <= node_next;
        found_reg <= found_next;
        hit_reg   <= hit_next;
        full_reg  <= (state_reg == ST_IDLE) ? 1'b0 : out_full_next;
        if (load)
        begin
            mode_reg <= q_mode;
            addr_reg <= q_addr;
            len_reg  <= q_len;
            port_reg <= q_port;
        end
        if (state_reg == ST_DONE && (!m_valid || take_out))
        begin
            m_hit    <= hit_reg;
            m_port   <= hit_reg ? route_rd[RW-1 -: PORT_BITS] : '0;
            m_len    <= hit_reg ? route_rd[ADDR_BITS +: 6] : '0;
            m_prefix <= hit_reg ? route_rd[ADDR_BITS-1:0] : '0;
            m_full   <= full_reg;
            m_nodes  <= 13'(alloc_reg);
        end
    end

    `BTL_ASSERT_IMP(a_alloc_ok, clk, rst_n, 1'b1, alloc_reg <= CB'(NODE_POOL) && alloc_reg != '0,
        "node count out of range")
    `BTL_ASSERT_IMP(a_full_ins, clk, rst_n, m_valid, !(m_full && m_hit), "full on a lookup hit")
    `BTL_ASSERT_NEXT(a_one_busy, clk, rst_n, load, state_reg == ST_RD, "item start lost")
    `BTL_ASSERT_IMP(a_fresh, clk, rst_n, fresh_cur_reg,
        state_reg == ST_ALLOC || state_reg == ST_MARK, "fresh node left without mark")
endmodule
`default_nettype wire

// ----- sv/binary_trie_longest_prefix_match_unit.sv -----
`default_nettype none
// Longest-prefix-match unit over a one-bit-per-level binary trie of IPv4
// routes. A two-entry input queue feeds a walker that makes one node-memory
// read per level, passing through read, wait and step states; an insert
// adds each missing node in an alloc state. The next item starts only
// after the previous result has been handed to the output register. One
// result leaves per item; nodes_in_use counts nodes after it.
module binary_trie_longest_prefix_match_unit #(
    parameter int NODE_POOL = btlpm_pkg::NodePool,
    parameter int ADDR_BITS = btlpm_pkg::AddrBits,
    parameter int PORT_BITS = btlpm_pkg::PortBits
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tuser: mode
    input  wire logic s_axis_tuser,
    // tdata: address, prefix_len, port_index (low to high), zero padded
    input  wire logic [((ADDR_BITS+6+PORT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tuser: hit, pool_full (low to high)
    output logic [1:0] m_axis_tuser,
    // tdata: out_port, matched_len, matched_prefix, nodes_in_use (low to high)
    output logic [((PORT_BITS+6+ADDR_BITS+13+7)/8)*8-1:0] m_axis_tdata
);
    import btlpm_pkg::*;

    localparam int OW = ((PORT_BITS+6+ADDR_BITS+13+7)/8)*8;

    logic                 q_valid, q_ready, q_mode;
    logic [ADDR_BITS-1:0] q_addr;
    logic [5:0]           q_len;
    logic [PORT_BITS-1:0] q_port;
    logic                 r_hit, r_full;
    logic [PORT_BITS-1:0] r_port;
    logic [5:0]           r_len;
    logic [ADDR_BITS-1:0] r_prefix;
    logic [12:0]          r_nodes;

    btlpm_front #(.ADDR_BITS(ADDR_BITS), .PORT_BITS(PORT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_mode(s_axis_tuser),
        .s_addr(s_axis_tdata[ADDR_BITS-1:0]),
        .s_len(s_axis_tdata[ADDR_BITS +: 6]),
        .s_port(s_axis_tdata[ADDR_BITS+6 +: PORT_BITS]),
        .q_valid(q_valid), .q_ready(q_ready), .q_mode(q_mode),
        .q_addr(q_addr), .q_len(q_len), .q_port(q_port)
    );

    btlpm_walk #(.NODE_POOL(NODE_POOL), .ADDR_BITS(ADDR_BITS), .PORT_BITS(PORT_BITS)) u_walk (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_mode(q_mode),
        .q_addr(q_addr), .q_len(q_len), .q_port(q_port),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_hit(r_hit), .m_port(r_port), .m_len(r_len), .m_prefix(r_prefix),
        .m_full(r_full), .m_nodes(r_nodes)
    );

    assign m_axis_tuser = {r_full, r_hit};
    assign m_axis_tdata = OW'({r_nodes, r_prefix, r_len, r_port});
endmodule
`default_nettype wire
